@@ rtl/mep_pkg.sv @@
// Package for the Mandelbrot escape-time pixel block.
// Holds the widths, fixed-point constants, register indexes and shared types.
// No dependencies.
package mep_pkg;

    localparam int COORD_BITS     = 12;
    localparam int FRAC_BITS      = 28;
    localparam int Q_BITS         = FRAC_BITS + 4;
    localparam int DIM_BITS       = 13;
    localparam int LIMIT_BITS     = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int NUM_BITS       = COORD_BITS + 1;
    localparam int DVD_BITS       = NUM_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DVD_BITS + 1);
    localparam int PROD_BITS      = 2 * Q_BITS;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT  = CFG_INDEX_BITS'(2);

    localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(1024);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = LIMIT_BITS'(256);

    localparam logic signed [Q_BITS-1:0] Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
    localparam logic signed [Q_BITS-1:0] Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};
    localparam logic [Q_BITS-1:0] OFFSET_RE = Q_BITS'(3) << (FRAC_BITS - 1);
    localparam logic [Q_BITS-1:0] OFFSET_IM = Q_BITS'(1) << FRAC_BITS;
    localparam logic [Q_BITS-1:0] Q_TWO     = Q_BITS'(1) << (FRAC_BITS + 1);
    localparam logic [DVD_BITS-1:0] MAP_LIMIT = DVD_BITS'(10) << FRAC_BITS;

    typedef struct packed {
        logic signed [Q_BITS-1:0] c_re;
        logic signed [Q_BITS-1:0] c_im;
    } t_point;

    // Turns a full division quotient into a saturated Q4.F coordinate.
    function automatic logic signed [Q_BITS-1:0] map_sat(
        input logic [DVD_BITS-1:0] q,
        input logic [Q_BITS-1:0]   offset
    );
        logic [DVD_BITS-1:0]      off_ext;
        logic [DVD_BITS-1:0]      diff;
        logic [Q_BITS-1:0]        neg;
        logic signed [Q_BITS-1:0] res;
        off_ext = DVD_BITS'(offset);
        diff    = '0;
        neg     = '0;
        if (q >= MAP_LIMIT) begin
            res = Q_MAX;
        end else if (q >= off_ext) begin
            diff = q - off_ext;
            if (diff > DVD_BITS'(Q_MAX)) begin
                res = Q_MAX;
            end else begin
                res = $signed(diff[Q_BITS-1:0]);
            end
        end else begin
            diff = off_ext - q;
            neg  = Q_BITS'(0) - diff[Q_BITS-1:0];
            res  = $signed(neg);
        end
        return res;
    endfunction

endpackage

@@ rtl/mandelbrot_escape_pixel.sv @@
// Mandelbrot escape-time test for one pixel in signed Q4.28 fixed point; uses mep_pkg,
// mep_front, mep_queue and mep_back. The front end maps a row and column to the point c
// with two bit-serial divisions, then writes the point into a two-entry queue and only
// then takes the next item, so it accepts no new item while one is still being mapped.
// The iteration engine pops a point and loads it, then runs each iteration as a multiply
// step followed by a test-and-update step, for one up to iteration_limit iterations
// (one when the limit is zero). The slower of the two sides sets the sustained rate.
// The result sits in an output register while the engine starts on the next point.
module mandelbrot_escape_pixel (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mep_pkg::COORD_BITS-1:0]     i_pixel_row,
    input  logic [mep_pkg::COORD_BITS-1:0]     i_pixel_column,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_inside_set,
    input  logic                               i_cfg_we,
    input  logic [mep_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mep_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import mep_pkg::*;

    logic [DIM_BITS-1:0]   r_image_height, r_image_width;
    logic [LIMIT_BITS-1:0] r_iteration_limit;
    logic                  push, full, pop, q_valid;
    t_point                front_point, queue_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_height    <= HEIGHT_RESET;
            r_image_width     <= WIDTH_RESET;
            r_iteration_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HEIGHT: r_image_height    <= i_cfg_data[DIM_BITS-1:0];
                REG_WIDTH:  r_image_width     <= i_cfg_data[DIM_BITS-1:0];
                REG_LIMIT:  r_iteration_limit <= i_cfg_data[LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mep_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_row    (i_pixel_row),
        .i_pixel_column (i_pixel_column),
        .i_image_height (r_image_height),
        .i_image_width  (r_image_width),
        .o_push         (push),
        .o_point        (front_point),
        .i_full         (full)
    );

    mep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (front_point),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_point (queue_point)
    );

    mep_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_point           (queue_point),
        .o_pop             (pop),
        .i_iteration_limit (r_iteration_limit),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_inside_set      (o_inside_set)
    );

endmodule

@@ rtl/mep_front.sv @@
// Front end: accepts a pixel and maps it to the point c by two bit-serial divisions.
// Pushes the point into the queue. Depends on mep_pkg.
module mep_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mep_pkg::COORD_BITS-1:0] i_pixel_row,
    input  logic [mep_pkg::COORD_BITS-1:0] i_pixel_column,
    input  logic [mep_pkg::DIM_BITS-1:0]   i_image_height,
    input  logic [mep_pkg::DIM_BITS-1:0]   i_image_width,
    output logic                          o_push,
    output mep_pkg::t_point               o_point,
    input  logic                          i_full
);
    import mep_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    typedef struct packed {
        logic [DIM_BITS-1:0] rem;
        logic [DVD_BITS-1:0] dvd;
    } t_div;

    logic [1:0]              r_state, n_state;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    t_div                    r_re, n_re, r_im, n_im;
    logic [DIM_BITS-1:0]     r_den_re, r_den_im;
    logic                    accept;

    // One restoring division step; the quotient bits fill the dividend from below.
    function automatic t_div div_step(input t_div cur, input logic [DIM_BITS-1:0] den);
        logic [DIM_BITS:0] rem_sh;
        logic              ge;
        t_div              nxt;
        rem_sh  = {cur.rem, cur.dvd[DVD_BITS-1]};
        ge      = rem_sh >= {1'b0, den};
        nxt.rem = ge ? DIM_BITS'(rem_sh - {1'b0, den}) : rem_sh[DIM_BITS-1:0];
        nxt.dvd = {cur.dvd[DVD_BITS-2:0], ge};
        return nxt;
    endfunction

    assign accept     = i_in_valid && (r_state == F_IDLE);
    assign o_in_stall = (r_state != F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_point.c_re = map_sat(r_re.dvd, OFFSET_RE);
    assign o_point.c_im = map_sat(r_im.dvd, OFFSET_IM);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_re    = r_re;
        n_im    = r_im;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_DIV;
                    n_cnt   = DIV_CNT_BITS'(DVD_BITS);
                    n_re    = '{rem: '0, dvd: {i_pixel_column, 1'b0, {FRAC_BITS{1'b0}}}};
                    n_im    = '{rem: '0, dvd: {i_pixel_row, 1'b0, {FRAC_BITS{1'b0}}}};
                end
            end
            F_DIV: begin
                n_re  = div_step(r_re, r_den_re);
                n_im  = div_step(r_im, r_den_im);
                n_cnt = r_cnt - DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_re  <= n_re;
        r_im  <= n_im;
        if (accept) begin
            r_den_re <= (i_image_width == '0) ? DIM_BITS'(1) : i_image_width;
            r_den_im <= (i_image_height == '0) ? DIM_BITS'(1) : i_image_height;
        end
    end

endmodule

@@ rtl/mep_queue.sv @@
// Short queue of mapped points between the front end and the iteration engine.
// Depends on mep_pkg.
module mep_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mep_pkg::t_point i_point,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mep_pkg::t_point o_point
);
    import mep_pkg::*;

    t_point                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count;
    logic                  do_push, do_pop;

    assign o_full   = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_point  = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : r_wr_ptr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : r_rd_ptr + QPTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_point;
        end
    end

endmodule

@@ rtl/mep_back.sv @@
// Iteration engine: runs z = z*z + c on one point, a multiply and an evaluate state a step, and holds the result.
// Depends on mep_pkg.
module mep_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  mep_pkg::t_point               i_point,
    output logic                          o_pop,
    input  logic [mep_pkg::LIMIT_BITS-1:0] i_iteration_limit,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_set
);
    import mep_pkg::*;

    localparam int SQ_BITS  = PROD_BITS - FRAC_BITS;
    localparam int SUM_BITS = PROD_BITS + 2;
    localparam logic [SQ_BITS:0] SQ_FOUR = (SQ_BITS+1)'(1) << (FRAC_BITS + 2);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_EVAL = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic signed [Q_BITS-1:0]    r_zr, r_zi, r_cre, r_cim;
    logic [LIMIT_BITS-1:0]       r_k;
    logic [PROD_BITS-1:0]        r_sq_r, r_sq_i;
    logic signed [PROD_BITS-1:0] r_cross;
    logic                        r_big;
    logic                        r_out_valid, r_inside;

    logic [Q_BITS-1:0]           mag_r, mag_i;
    logic [SQ_BITS-1:0]          sr, si;
    logic [SQ_BITS:0]            sq_sum;
    logic signed [SUM_BITS-1:0]  nr_wide, ni_wide;
    logic                        escaped, last, finish, out_free;

    function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [SUM_BITS-1:0] v);
        logic signed [Q_BITS-1:0] res;
        if (v > SUM_BITS'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < SUM_BITS'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = v[Q_BITS-1:0];
        end
        return res;
    endfunction

    assign mag_r = r_zr[Q_BITS-1] ? Q_BITS'(0) - r_zr : r_zr;
    assign mag_i = r_zi[Q_BITS-1] ? Q_BITS'(0) - r_zi : r_zi;

    assign sr      = r_sq_r[PROD_BITS-1:FRAC_BITS];
    assign si      = r_sq_i[PROD_BITS-1:FRAC_BITS];
    assign sq_sum  = {1'b0, sr} + {1'b0, si};
    assign nr_wide = SUM_BITS'($signed({1'b0, sr})) - SUM_BITS'($signed({1'b0, si}))
                   + SUM_BITS'(r_cre);
    assign ni_wide = SUM_BITS'(r_cross >>> (FRAC_BITS - 1)) + SUM_BITS'(r_cim);

    assign escaped  = (i_iteration_limit == '0) || r_big || (sq_sum >= SQ_FOUR);
    assign last     = ({1'b0, r_k} + (LIMIT_BITS+1)'(1)) == {1'b0, i_iteration_limit};
    assign finish   = escaped || last;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_pop        = (r_state == B_IDLE) && i_q_valid;
    assign o_out_valid  = r_out_valid;
    assign o_inside_set = r_inside;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_EVAL;
            end
            B_EVAL: begin
                if (!finish) begin
                    n_state = B_MUL;
                end else if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == B_EVAL) && finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == B_EVAL) && finish && out_free) begin
            r_inside <= !escaped;
        end
        if (o_pop) begin
            r_cre <= i_point.c_re;
            r_cim <= i_point.c_im;
            r_zr  <= '0;
            r_zi  <= '0;
            r_k   <= '0;
        end else if ((r_state == B_EVAL) && !finish) begin
            r_zr <= sat_q(nr_wide);
            r_zi <= sat_q(ni_wide);
            r_k  <= r_k + LIMIT_BITS'(1);
        end
        if (r_state == B_MUL) begin
            r_sq_r  <= mag_r * mag_r;
            r_sq_i  <= mag_i * mag_i;
            r_cross <= r_zr * r_zi;
            r_big   <= (mag_r >= Q_TWO) || (mag_i >= Q_TWO);
        end
    end

endmodule

@@ rtl/mep_checker.sv @@
// Port-level checks for the Mandelbrot escape-time pixel block, bound to the top level.
// Depends only on the top level's handshake and configuration ports.
module mep_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_inside_set,
    input logic i_cfg_we
);

    logic       in_accept, out_accept;
    logic [3:0] r_in_flight;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else begin
            r_in_flight <= r_in_flight + 4'(in_accept) - 4'(out_accept);
        end
    end

    // A stalled result stays and holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_inside_set))
        else $error("result changed while stalled");

    // Leaving reset, no result is pending and the input side is open.
    a_reset_clear: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not clear after reset");

    // After an item is accepted, the coordinate divisions keep the input side closed.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input accepted during coordinate mapping");

    // A result is only offered for an item that was accepted and not yet returned.
    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_in_flight != '0)
        else $error("result without a pending item");

    // Registers are to be written by the user only while no item is in the block; the block does not enforce it.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> r_in_flight == '0)
        else $error("register written while items are in flight");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (.*);

@@ verif/mandelbrot_escape_pixel_test.sv @@
// Self-checking testbench for mandelbrot_escape_pixel: a Q4.28 escape-time predictor checks
// every pixel result under random handshake idling and a series of register settings.
// Depends on mep_pkg and the RTL of mandelbrot_escape_pixel.
module mandelbrot_escape_pixel_test;
    import mep_pkg::*;

    localparam int QUIET_LIMIT      = 400000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PIXELS_PER_PHASE = 50;
    localparam int COORD_SPAN       = 1 << COORD_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = CFG_INDEX_BITS'(3);

    localparam longint FIX_MAX       = (longint'(1) << (FRAC_BITS + 3)) - 1;
    localparam longint FIX_MIN       = -FIX_MAX - 1;
    localparam longint FIX_TWO       = longint'(1) << (FRAC_BITS + 1);
    localparam longint FIX_FOUR      = longint'(1) << (FRAC_BITS + 2);
    localparam longint FIX_OFF_RE    = longint'(3) << (FRAC_BITS - 1);
    localparam longint FIX_OFF_IM    = longint'(1) << FRAC_BITS;
    localparam longint FIX_MAP_LIMIT = longint'(10) << FRAC_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] column;
    } t_pixel;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic [COORD_BITS-1:0]     i_pixel_row    = '0;
    logic [COORD_BITS-1:0]     i_pixel_column = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic                      o_inside_set;
    logic                      i_cfg_we       = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index    = REG_HEIGHT;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data     = '0;

    logic [DIM_BITS-1:0]   cfg_height = HEIGHT_RESET;
    logic [DIM_BITS-1:0]   cfg_width  = WIDTH_RESET;
    logic [LIMIT_BITS-1:0] cfg_limit  = LIMIT_RESET;

    t_pixel pending_pixels[$];
    logic   expected_inside[$];
    bit     bursts_on     = 1'b1;
    int     in_gap        = 0;
    int     out_hold      = 0;
    int     quiet_cycles  = 0;
    int     bad_results   = 0;
    int     inside_count  = 0;
    int     escaped_count = 0;
    int     settings_used = 1;

    mandelbrot_escape_pixel DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_row    (i_pixel_row),
        .i_pixel_column (i_pixel_column),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_set   (o_inside_set),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint sat_fix(input longint x);
        if (x > FIX_MAX) begin
            return FIX_MAX;
        end
        if (x < FIX_MIN) begin
            return FIX_MIN;
        end
        return x;
    endfunction

    // The quotient cannot drop below minus the offset, so only the top needs clipping.
    function automatic longint map_point(input longint num, input longint den,
                                         input longint offset);
        longint q;
        q = (num << FRAC_BITS) / den;
        if (q >= FIX_MAP_LIMIT) begin
            return FIX_MAX;
        end
        return sat_fix(q - offset);
    endfunction

    function automatic logic predict_inside(input t_pixel px);
        longint      den_h, den_w, c_re, c_im, z_re, z_im, sq_re, sq_im, next_re;
        int unsigned step;
        logic        done, in_set;
        den_h  = (cfg_height == 0) ? 1 : longint'(cfg_height);
        den_w  = (cfg_width == 0) ? 1 : longint'(cfg_width);
        c_re   = map_point(2 * longint'(px.column), den_w, FIX_OFF_RE);
        c_im   = map_point(2 * longint'(px.row), den_h, FIX_OFF_IM);
        z_re   = 0;
        z_im   = 0;
        step   = 0;
        done   = 1'b0;
        in_set = 1'b0;
        while (!done && step < cfg_limit) begin
            if ((z_re < 0 ? -z_re : z_re) >= FIX_TWO || (z_im < 0 ? -z_im : z_im) >= FIX_TWO) begin
                done = 1'b1;
            end else begin
                sq_re = (z_re * z_re) >>> FRAC_BITS;
                sq_im = (z_im * z_im) >>> FRAC_BITS;
                if (sq_re + sq_im >= FIX_FOUR) begin
                    done = 1'b1;
                end else if (step + 1 == cfg_limit) begin
                    in_set = 1'b1;
                    done   = 1'b1;
                end else begin
                    next_re = sat_fix(sq_re - sq_im + c_re);
                    z_im    = sat_fix(((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im);
                    z_re    = next_re;
                end
            end
            step++;
        end
        return in_set;
    endfunction

    // Most pixels lie inside the image; one in eight may use any coordinate at all.
    function automatic t_pixel random_pixel();
        t_pixel      px;
        int unsigned rows, cols;
        rows = (cfg_height == 0) ? 1 : ((cfg_height > COORD_SPAN) ? COORD_SPAN : cfg_height);
        cols = (cfg_width == 0) ? 1 : ((cfg_width > COORD_SPAN) ? COORD_SPAN : cfg_width);
        if ($urandom_range(0, 7) == 0) begin
            px.row    = COORD_BITS'($urandom);
            px.column = COORD_BITS'($urandom);
        end else begin
            px.row    = COORD_BITS'($urandom_range(0, rows - 1));
            px.column = COORD_BITS'($urandom_range(0, cols - 1));
        end
        return px;
    endfunction

    function automatic void queue_pixel(input int row, input int column);
        t_pixel px;
        px.row    = COORD_BITS'(row);
        px.column = COORD_BITS'(column);
        pending_pixels.push_back(px);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_HEIGHT: begin
                cfg_height = data[DIM_BITS-1:0];
            end
            REG_WIDTH: begin
                cfg_width = data[DIM_BITS-1:0];
            end
            REG_LIMIT: begin
                cfg_limit = data[LIMIT_BITS-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || i_in_valid || expected_inside.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_inside.push_back(predict_inside({i_pixel_row, i_pixel_column}));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap != 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    t_pixel px;
                    px = pending_pixels.pop_front();
                    i_pixel_row    <= px.row;
                    i_pixel_column <= px.column;
                    i_in_valid     <= 1'b1;
                    if (bursts_on && $urandom_range(0, 3) == 0) begin
                        in_gap = $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_inside.size() == 0) begin
                    $error("inside_set: expected no item, actual %0b", o_inside_set);
                    bad_results++;
                end else begin
                    logic want;
                    want = expected_inside.pop_front();
                    if (o_inside_set !== want) begin
                        $error("inside_set: expected %0b, actual %0b", want, o_inside_set);
                        bad_results++;
                    end
                    if (want) begin
                        inside_count++;
                    end else begin
                        escaped_count++;
                    end
                end
            end
            if (out_hold != 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else if (bursts_on && $urandom_range(0, 3) == 0) begin
                out_hold = $urandom_range(0, 6);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [CFG_DATA_BITS-1:0] height, width, limit;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners, the origin, points on the real axis and beyond the image.
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(0, 4095);
        queue_pixel(4095, 0);
        queue_pixel(512, 768);
        queue_pixel(512, 256);
        queue_pixel(2048, 1024);
        queue_pixel(1023, 1023);
        queue_pixel(512, 1023);
        wait_idle();

        // A zero iteration limit reports every pixel as escaped.
        write_reg(REG_LIMIT, 16'd0);
        settings_used++;
        queue_pixel(512, 768);
        queue_pixel(0, 0);
        wait_idle();

        // Zero image sizes act as one; a limit of one marks every pixel inside.
        write_reg(REG_HEIGHT, 16'd0);
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_LIMIT, 16'd1);
        settings_used++;
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(4095, 4095);
        wait_idle();

        // The spare index is ignored and high data bits fall outside the size registers.
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_HEIGHT, 16'hE002);
        write_reg(REG_WIDTH, 16'd4);
        write_reg(REG_LIMIT, 16'hFFFF);
        settings_used++;
        queue_pixel(1, 3);
        queue_pixel(0, 0);
        queue_pixel(2, 4);
        queue_pixel(4095, 4095);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    height = 16'd4096;
                    width  = 16'd4096;
                    limit  = 16'd32;
                end
                1: begin
                    height = 16'd1;
                    width  = 16'd1;
                    limit  = 16'd8;
                end
                2: begin
                    height = 16'hFFFF;
                    width  = 16'h1FFF;
                    limit  = 16'd24;
                end
                default: begin
                    height = CFG_DATA_BITS'($urandom_range(0, 1) ? $urandom_range(1, 64)
                                                                 : $urandom_range(1, 4096));
                    width  = CFG_DATA_BITS'($urandom_range(0, 1) ? $urandom_range(1, 64)
                                                                 : $urandom_range(1, 4096));
                    limit  = CFG_DATA_BITS'($urandom_range(1, 40));
                end
            endcase
            bursts_on = (phase != RANDOM_PHASES - 1);
            write_reg(REG_HEIGHT, height);
            write_reg(REG_WIDTH, width);
            write_reg(REG_LIMIT, limit);
            settings_used++;
            repeat (PIXELS_PER_PHASE) pending_pixels.push_back(random_pixel());
            wait_idle();
        end

        repeat (64) @(posedge i_clk);
        $display("Checked %0d pixels (%0d inside, %0d escaped) under %0d register settings.",
                 inside_count + escaped_count, inside_count, escaped_count, settings_used);
        if (bad_results == 0 && expected_inside.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
